### src/ngd_pkg.sv
`default_nettype none

package ngd_pkg;

	localparam int RECEPTORS = 31;
	localparam int POS_W     = 5;
	localparam int CENTER    = RECEPTORS / 2;

	localparam int PIX_W     = 8;
	localparam int WGT_W     = 16;
	localparam int WREG_W    = 3 * WGT_W;
	localparam int MASK_W    = 3;
	localparam int PROD_W    = WGT_W + PIX_W + 1;
	localparam int DOT_W     = PROD_W + 2;
	localparam int MAG_W     = 18;
	localparam int ANGLE_W   = 6;
	localparam int IN_W      = 3 * PIX_W;
	localparam int OUT_W     = 8;

	localparam logic [POS_W-1:0]   POS_LAST    = POS_W'(RECEPTORS - 1);
	localparam logic [ANGLE_W-1:0] ANGLE_CTR   = ANGLE_W'(CENTER);
	localparam logic [ANGLE_W-1:0] ANGLE_BLANK = ANGLE_W'(30);

	typedef enum logic [1:0] {
		REG_CLASS0,
		REG_CLASS1,
		REG_CLASS2,
		REG_NUTRIENT
	} cfg_reg_t;

	typedef logic [1:0] class_t;

	typedef struct packed {
		logic                      found_any;
		logic                      found_food;
		logic signed [ANGLE_W-1:0] gaze_angle;
	} result_t;

	function automatic logic signed [DOT_W-1:0] dot3(
		input logic [WREG_W-1:0] w,
		input logic [PIX_W-1:0]  r,
		input logic [PIX_W-1:0]  g,
		input logic [PIX_W-1:0]  b
	);
		logic signed [PROD_W-1:0] pr;
		logic signed [PROD_W-1:0] pg;
		logic signed [PROD_W-1:0] pb;
		pr = PROD_W'($signed(w[WGT_W-1:0]) * $signed({1'b0, r}));
		pg = PROD_W'($signed(w[2*WGT_W-1:WGT_W]) * $signed({1'b0, g}));
		pb = PROD_W'($signed(w[3*WGT_W-1:2*WGT_W]) * $signed({1'b0, b}));
		return DOT_W'(pr) + DOT_W'(pg) + DOT_W'(pb);
	endfunction

	function automatic logic [MAG_W-1:0] mag3(
		input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b
	);
		return MAG_W'(r * r) + MAG_W'(g * g) + MAG_W'(b * b);
	endfunction

endpackage

`default_nettype wire

### src/nutrient_gaze_direction.sv
// Gaze direction from one scan row of RGB receptor samples.
//
// Slave stream: one receptor per transaction, tdata = {blue, green, red} with
// red in the lowest byte, tlast marks the final receptor of the row.
// Master stream: one result per row, sent for the tlast transaction only,
// tdata = {found_any, found_food, gaze_angle[5:0]} with the angle lowest.
// Configuration: cfg_we writes cfg_data into register cfg_index (0..2 class
// weights, 3 nutrient mask); write only while the block holds no row work.
//
// A row result is registered once its tlast sample has left the input register
// and the product stage. Throughput: one sample per cycle while no master stall
// holds a row end, via the input, product and compare/update stages.
// Reset clears the weights, the mask, the row state and both stream sides.
// A stall on the master side holds the result; the two internal stages keep
// filling until both are occupied, then s_axis_tready drops.

`default_nettype none

module nutrient_gaze_direction (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 cfg_we,
	input  wire  [1:0]                          cfg_index,
	input  wire  [ngd_pkg::WREG_W-1:0]          cfg_data,
	input  wire                                 s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire  [ngd_pkg::IN_W-1:0]            s_axis_tdata,  // red, green, blue
	input  wire                                 s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  wire                                 m_axis_tready,
	output logic [ngd_pkg::OUT_W-1:0]           m_axis_tdata   // gaze_angle, found_food, found_any
);

	logic [ngd_pkg::WREG_W-1:0] w0_q, w1_q, w2_q;
	logic [ngd_pkg::MASK_W-1:0] mask_q;

	logic                       v_s1;
	logic [ngd_pkg::PIX_W-1:0]  r_s1, g_s1, b_s1;
	logic                       last_s1;

	logic                       v_s2;
	logic signed [ngd_pkg::DOT_W-1:0] d0_s2, d1_s2, d2_s2;
	logic [ngd_pkg::MAG_W-1:0]  mag_s2;
	logic                       last_s2;

	logic [ngd_pkg::POS_W-1:0]  pos_q;
	logic [ngd_pkg::MAG_W-1:0]  bfm_q, bam_q;
	logic [ngd_pkg::POS_W-1:0]  bfp_q, bap_q;

	logic                       ov_q;
	ngd_pkg::result_t           res_q;

	logic out_free, go2, en2, en1;
	logic signed [ngd_pkg::DOT_W-1:0] top;
	ngd_pkg::class_t            win;
	logic                       food;
	logic [ngd_pkg::MAG_W-1:0]  bfm_n, bam_n;
	logic [ngd_pkg::POS_W-1:0]  bfp_n, bap_n;
	ngd_pkg::result_t           res_n;

	assign out_free      = !ov_q || m_axis_tready;
	assign go2           = v_s2 && (!last_s2 || out_free);
	assign en2           = !v_s2 || go2;
	assign en1           = !v_s1 || en2;
	assign s_axis_tready = en1;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q   <= '0;
			w1_q   <= '0;
			w2_q   <= '0;
			mask_q <= '0;
		end else if (cfg_we) begin
			case (ngd_pkg::cfg_reg_t'(cfg_index))
				ngd_pkg::REG_CLASS0:   w0_q   <= cfg_data;
				ngd_pkg::REG_CLASS1:   w1_q   <= cfg_data;
				ngd_pkg::REG_CLASS2:   w2_q   <= cfg_data;
				ngd_pkg::REG_NUTRIENT: mask_q <= cfg_data[ngd_pkg::MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= s_axis_tvalid;
			if (en2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_axis_tvalid) begin
			r_s1    <= s_axis_tdata[ngd_pkg::PIX_W-1:0];
			g_s1    <= s_axis_tdata[2*ngd_pkg::PIX_W-1:ngd_pkg::PIX_W];
			b_s1    <= s_axis_tdata[3*ngd_pkg::PIX_W-1:2*ngd_pkg::PIX_W];
			last_s1 <= s_axis_tlast;
		end
		if (en2 && v_s1) begin
			d0_s2   <= ngd_pkg::dot3(w0_q, r_s1, g_s1, b_s1);
			d1_s2   <= ngd_pkg::dot3(w1_q, r_s1, g_s1, b_s1);
			d2_s2   <= ngd_pkg::dot3(w2_q, r_s1, g_s1, b_s1);
			mag_s2  <= ngd_pkg::mag3(r_s1, g_s1, b_s1);
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		top = '0;
		win = 2'd0;
		if (d0_s2 > top) begin
			top = d0_s2;
			win = 2'd0;
		end
		if (d1_s2 > top) begin
			top = d1_s2;
			win = 2'd1;
		end
		if (d2_s2 > top) begin
			top = d2_s2;
			win = 2'd2;
		end
		food = mask_q[win];

		bam_n = bam_q;
		bap_n = bap_q;
		if (mag_s2 > bam_q) begin
			bam_n = mag_s2;
			bap_n = pos_q;
		end
		bfm_n = bfm_q;
		bfp_n = bfp_q;
		if (food && mag_s2 > bfm_q) begin
			bfm_n = mag_s2;
			bfp_n = pos_q;
		end

		if (bfm_n != '0) begin
			res_n.gaze_angle = $signed({1'b0, bfp_n} - ngd_pkg::ANGLE_CTR);
			res_n.found_food = 1'b1;
			res_n.found_any  = 1'b1;
		end else if (bam_n != '0) begin
			res_n.gaze_angle = $signed({1'b0, bap_n} - ngd_pkg::ANGLE_CTR);
			res_n.found_food = 1'b0;
			res_n.found_any  = 1'b1;
		end else begin
			res_n.gaze_angle = $signed(ngd_pkg::ANGLE_BLANK);
			res_n.found_food = 1'b0;
			res_n.found_any  = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bfm_q <= '0;
			bfp_q <= '0;
			bam_q <= '0;
			bap_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (go2) begin
				if (last_s2) begin
					pos_q <= '0;
					bfm_q <= '0;
					bfp_q <= '0;
					bam_q <= '0;
					bap_q <= '0;
				end else begin
					if (pos_q < ngd_pkg::POS_LAST)
						pos_q <= pos_q + 1'b1;
					bfm_q <= bfm_n;
					bfp_q <= bfp_n;
					bam_q <= bam_n;
					bap_q <= bap_n;
				end
			end
			if (go2 && last_s2)
				ov_q <= 1'b1;
			else if (m_axis_tready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go2 && last_s2)
			res_q <= res_n;
	end

endmodule

`default_nettype wire

### src/ngd_checker.sv
`default_nettype none

module ngd_checker (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        m_axis_tvalid,
	input wire                        m_axis_tready,
	input wire [ngd_pkg::OUT_W-1:0]   m_axis_tdata
);

	ngd_pkg::result_t res;
	assign res = m_axis_tdata;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_food_any: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.found_food |-> res.found_any)
		else $error("food found without any receptor seen");

	a_blank: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !res.found_any |->
			res.gaze_angle == $signed(ngd_pkg::ANGLE_BLANK))
		else $error("empty row gives wrong angle");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && res.found_any |->
			res.gaze_angle >= -$signed(ngd_pkg::ANGLE_CTR) &&
			res.gaze_angle <= $signed(ngd_pkg::ANGLE_CTR))
		else $error("gaze angle out of receptor range");

endmodule

bind nutrient_gaze_direction ngd_checker u_ngd_checker (.*);

`default_nettype wire
